>>> hw/rtl/ihb_pkg.sv
// Shared types and constants of the IPv4 header builder.
package ihb_pkg;

  localparam int          HDR_BYTES   = 20;
  localparam int          HDR_IDX_W   = 5;
  localparam int          CK_WORDS    = 9;
  localparam logic [15:0] MAX_PAYLOAD = 16'd65515;
  localparam logic [31:0] SUBNET_MASK = 32'hFFFF_FF00;
  localparam logic [7:0]  VER_IHL     = 8'h45;
  localparam logic [7:0]  FLAGS_DF    = 8'h40;
  localparam logic [7:0]  TTL_DEFAULT = 8'd64;
  localparam logic [7:0]  ZERO_BYTE   = 8'h00;

  localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HDR_BYTES - 1);

  // Input function codes
  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_PAYLOAD = 1'b1;

  // Register indexes on the configuration port
  localparam logic REG_LOCAL   = 1'b0;
  localparam logic REG_GATEWAY = 1'b1;

  // One unit of work handed from front to back
  typedef struct packed {
    logic        is_hdr;
    logic        last;
    logic [31:0] hop;
    logic [31:0] src;
    logic [31:0] dest;
    logic [15:0] total;
    logic [15:0] ident;
    logic [7:0]  proto;
    logic [7:0]  data;
  } desc_t;

endpackage

>>> hw/rtl/ipv4_header_builder.sv
// Top level of the IPv4 header builder: configuration registers, front, queue, back.
// An accepted word enters the queue; its first byte then goes into the output register.
// Throughput: payload words at one per cycle unless output stalls; a start word holds the
// back end for its 20 header bytes; QUEUE_DEPTH-1 words wait behind it, then input stalls.
// Reset (synchronous, rst_n low): addresses, identification, remaining length, next hop,
// queue and output valid clear to zero; no clearing pass is needed.
module ipv4_header_builder
  import ihb_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [31:0] in_dest_address,
  input  logic [7:0]  in_proto_number,
  input  logic [15:0] in_payload_length,
  input  logic [7:0]  in_data_byte,
  // output words
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_header_flag,
  output logic [31:0] out_hop_address,
  output logic        out_packet_end,
  // APB-style configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] local_r, local_nxt;
  logic [31:0] gateway_r, gateway_nxt;
  logic        reg_sel;
  logic        cfg_write;

  logic  q_full;
  logic  q_push;
  desc_t q_push_desc;
  logic  q_pop;
  logic  q_valid;
  desc_t q_head;

  // Register map: one 32-bit register per word address; byte offset bits are ignored.
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    local_nxt   = local_r;
    gateway_nxt = gateway_r;
    if (cfg_write) begin
      unique case (reg_sel)
        REG_LOCAL:   local_nxt   = pwdata;
        REG_GATEWAY: gateway_nxt = pwdata;
        default:     local_nxt   = local_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_LOCAL:   prdata = local_r;
      REG_GATEWAY: prdata = gateway_r;
      default:     prdata = 32'h0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_r   <= '0;
      gateway_r <= '0;
    end else begin
      local_r   <= local_nxt;
      gateway_r <= gateway_nxt;
    end
  end

  // Front: classify words, track identification, remaining length and next hop.
  ihb_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_dest_address   (in_dest_address),
    .in_proto_number   (in_proto_number),
    .in_payload_length (in_payload_length),
    .in_data_byte      (in_data_byte),
    .local_addr        (local_r),
    .gateway_addr      (gateway_r),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_desc            (q_push_desc)
  );

  // Queue: hold descriptors so the front keeps accepting during header bursts.
  ihb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head_desc (q_head)
  );

  // Back: serialize header bytes with checksum, pass payload bytes, register output.
  ihb_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_desc          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_header_flag (out_header_flag),
    .out_hop_address (out_hop_address),
    .out_packet_end  (out_packet_end)
  );

endmodule

>>> hw/rtl/ihb_front.sv
// Front end: accept words, classify them and keep per-packet state.
module ihb_front
  import ihb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [31:0] in_dest_address,
  input  logic [7:0]  in_proto_number,
  input  logic [15:0] in_payload_length,
  input  logic [7:0]  in_data_byte,
  input  logic [31:0] local_addr,
  input  logic [31:0] gateway_addr,
  input  logic        q_full,
  output logic        q_push,
  output desc_t       q_desc
);

  logic [15:0] ident_r, ident_nxt;
  logic [15:0] left_r, left_nxt;
  logic [31:0] hop_r, hop_nxt;

  logic        accept;
  logic [15:0] plen;
  logic [15:0] total;
  logic [31:0] hop_new;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    plen    = (in_payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD : in_payload_length;
    total   = plen + 16'(HDR_BYTES);
    hop_new = (|((in_dest_address ^ local_addr) & SUBNET_MASK)) ? gateway_addr
                                                                 : in_dest_address;
  end

  always_comb begin
    ident_nxt = ident_r;
    left_nxt  = left_r;
    hop_nxt   = hop_r;
    q_push    = 1'b0;
    q_desc    = '0;
    if (accept) begin
      if (in_func == FUNC_START) begin
        ident_nxt    = ident_r + 16'd1;
        left_nxt     = plen;
        hop_nxt      = hop_new;
        q_push       = 1'b1;
        q_desc.is_hdr = 1'b1;
        q_desc.last  = (plen == 16'd0);
        q_desc.hop   = hop_new;
        q_desc.src   = local_addr;
        q_desc.dest  = in_dest_address;
        q_desc.total = total;
        q_desc.ident = ident_r;
        q_desc.proto = in_proto_number;
      end else if (left_r != 16'd0) begin
        // drop stray bytes: only forward while payload is expected
        left_nxt     = left_r - 16'd1;
        q_push       = 1'b1;
        q_desc.last  = (left_r == 16'd1);
        q_desc.hop   = hop_r;
        q_desc.data  = in_data_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ident_r <= '0;
      left_r  <= '0;
      hop_r   <= '0;
    end else begin
      ident_r <= ident_nxt;
      left_r  <= left_nxt;
      hop_r   <= hop_nxt;
    end
  end

endmodule

>>> hw/rtl/ihb_queue.sv
// Short descriptor queue between front and back end.
module ihb_queue
  import ihb_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output desc_t head_desc
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  desc_t             slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_desc = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> hw/rtl/ihb_back.sv
// Back end: expand descriptors into bytes, fold the checksum, drive the output.
module ihb_back
  import ihb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  desc_t       q_desc,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_header_flag,
  output logic [31:0] out_hop_address,
  output logic        out_packet_end
);

  logic [HDR_IDX_W-1:0] idx_r, idx_nxt;
  logic [15:0]          acc_r, acc_nxt;
  logic                 valid_r, valid_nxt;
  logic [7:0]           byte_r, byte_nxt;
  logic                 hdr_r, hdr_nxt;
  logic [31:0]          hop_r, hop_nxt;
  logic                 end_r, end_nxt;

  logic        load;
  logic [15:0] word;
  logic [15:0] acc_base;
  logic [16:0] acc_sum;
  logic [7:0]  hdr_byte;

  assign load = q_valid && (!valid_r || out_ready);

  // checksum word taken at header positions zero through eight
  always_comb begin
    unique case (idx_r)
      5'd0:    word = {VER_IHL, ZERO_BYTE};
      5'd1:    word = q_desc.total;
      5'd2:    word = q_desc.ident;
      5'd3:    word = {FLAGS_DF, ZERO_BYTE};
      5'd4:    word = {TTL_DEFAULT, q_desc.proto};
      5'd5:    word = q_desc.src[31:16];
      5'd6:    word = q_desc.src[15:0];
      5'd7:    word = q_desc.dest[31:16];
      5'd8:    word = q_desc.dest[15:0];
      default: word = 16'h0000;
    endcase
  end

  always_comb begin
    acc_base = (idx_r == '0) ? 16'h0000 : acc_r;
    acc_sum  = {1'b0, acc_base} + {1'b0, word};
  end

  always_comb begin
    unique case (idx_r)
      5'd0:    hdr_byte = VER_IHL;
      5'd1:    hdr_byte = ZERO_BYTE;
      5'd2:    hdr_byte = q_desc.total[15:8];
      5'd3:    hdr_byte = q_desc.total[7:0];
      5'd4:    hdr_byte = q_desc.ident[15:8];
      5'd5:    hdr_byte = q_desc.ident[7:0];
      5'd6:    hdr_byte = FLAGS_DF;
      5'd7:    hdr_byte = ZERO_BYTE;
      5'd8:    hdr_byte = TTL_DEFAULT;
      5'd9:    hdr_byte = q_desc.proto;
      5'd10:   hdr_byte = ~acc_r[15:8];
      5'd11:   hdr_byte = ~acc_r[7:0];
      5'd12:   hdr_byte = q_desc.src[31:24];
      5'd13:   hdr_byte = q_desc.src[23:16];
      5'd14:   hdr_byte = q_desc.src[15:8];
      5'd15:   hdr_byte = q_desc.src[7:0];
      5'd16:   hdr_byte = q_desc.dest[31:24];
      5'd17:   hdr_byte = q_desc.dest[23:16];
      5'd18:   hdr_byte = q_desc.dest[15:8];
      5'd19:   hdr_byte = q_desc.dest[7:0];
      default: hdr_byte = ZERO_BYTE;
    endcase
  end

  always_comb begin
    idx_nxt   = idx_r;
    acc_nxt   = acc_r;
    valid_nxt = valid_r && !out_ready;
    byte_nxt  = byte_r;
    hdr_nxt   = hdr_r;
    hop_nxt   = hop_r;
    end_nxt   = end_r;
    q_pop     = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      hop_nxt   = q_desc.hop;
      if (q_desc.is_hdr) begin
        byte_nxt = hdr_byte;
        hdr_nxt  = 1'b1;
        end_nxt  = q_desc.last && (idx_r == HDR_LAST);
        if (idx_r < HDR_IDX_W'(CK_WORDS)) begin
          // end-around carry on every step
          acc_nxt = acc_sum[15:0] + 16'(acc_sum[16]);
        end
        if (idx_r == HDR_LAST) begin
          idx_nxt = '0;
          q_pop   = 1'b1;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end else begin
        byte_nxt = q_desc.data;
        hdr_nxt  = 1'b0;
        end_nxt  = q_desc.last;
        q_pop    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    byte_r <= byte_nxt;
    hdr_r  <= hdr_nxt;
    hop_r  <= hop_nxt;
    end_r  <= end_nxt;
  end

  assign out_valid       = valid_r;
  assign out_byte        = byte_r;
  assign out_header_flag = hdr_r;
  assign out_hop_address = hop_r;
  assign out_packet_end  = end_r;

endmodule

>>> dv/ipv4_header_checker.sv
// Checker for the IPv4 header builder: watches the data ports and config writes, predicts and compares output words.
module ipv4_header_checker
  import ihb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_func,
  input  logic [31:0] in_dest_address,
  input  logic [7:0]  in_proto_number,
  input  logic [15:0] in_payload_length,
  input  logic [7:0]  in_data_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic        out_header_flag,
  input  logic [31:0] out_hop_address,
  input  logic        out_packet_end,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [7:0]  octet;
    logic        hdr;
    logic [31:0] hop;
    logic        last;
  } frame_word_t;

  frame_word_t frame_q[$];

  logic [31:0] local_addr;
  logic [31:0] gw_addr;
  logic [15:0] next_ident;
  logic [15:0] payload_owed;
  logic [31:0] hop_now;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic void frame_header(input logic [31:0] dest, input logic [7:0] proto,
                                        input logic [15:0] len);
    logic [15:0] plen;
    logic [15:0] total;
    logic [31:0] acc;
    logic [15:0] csum;
    logic [7:0]  hdr [HDR_BYTES];
    frame_word_t w;
    plen  = (len > MAX_PAYLOAD) ? MAX_PAYLOAD : len;
    total = plen + 16'(HDR_BYTES);
    hop_now = (((dest ^ local_addr) & SUBNET_MASK) != 32'd0) ? gw_addr : dest;
    hdr[0]  = VER_IHL;
    hdr[1]  = ZERO_BYTE;
    hdr[2]  = total[15:8];
    hdr[3]  = total[7:0];
    hdr[4]  = next_ident[15:8];
    hdr[5]  = next_ident[7:0];
    hdr[6]  = FLAGS_DF;
    hdr[7]  = ZERO_BYTE;
    hdr[8]  = TTL_DEFAULT;
    hdr[9]  = proto;
    hdr[10] = ZERO_BYTE;
    hdr[11] = ZERO_BYTE;
    for (int i = 0; i < 4; i++) begin
      hdr[12 + i] = local_addr[31 - 8 * i -: 8];
      hdr[16 + i] = dest[31 - 8 * i -: 8];
    end
    acc = 32'd0;
    for (int i = 0; i < HDR_BYTES; i += 2)
      acc += {16'd0, hdr[i], hdr[i + 1]};
    // fold carries twice: the first fold can itself carry once
    acc  = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
    acc  = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
    csum = ~acc[15:0];
    hdr[10] = csum[15:8];
    hdr[11] = csum[7:0];
    next_ident   = next_ident + 16'd1;
    payload_owed = plen;
    for (int i = 0; i < HDR_BYTES; i++) begin
      w.octet = hdr[i];
      w.hdr   = 1'b1;
      w.hop   = hop_now;
      w.last  = (i == HDR_BYTES - 1) && (plen == 16'd0);
      frame_q.push_back(w);
    end
  endfunction

  always @(posedge clk) begin : watch
    frame_word_t w;
    if (!rst_n) begin
      local_addr   = 32'd0;
      gw_addr      = 32'd0;
      next_ident   = 16'd0;
      payload_owed = 16'd0;
      hop_now      = 32'd0;
      frame_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_LOCAL) local_addr = pwdata;
        else gw_addr = pwdata;
      end
      if (in_valid && in_ready) begin
        if (in_func == FUNC_START) begin
          frame_header(in_dest_address, in_proto_number, in_payload_length);
        end else if (payload_owed != 16'd0) begin
          w.octet = in_data_byte;
          w.hdr   = 1'b0;
          w.hop   = hop_now;
          w.last  = (payload_owed == 16'd1);
          frame_q.push_back(w);
          payload_owed = payload_owed - 16'd1;
        end
        // drop stray payload words: nothing is expected for them
      end
      if (out_valid && out_ready) begin
        if (frame_q.size() == 0) begin
          if (fail_count < 10)
            $display("[%0t] unexpected output word: byte %02h hdr %0b hop %08h end %0b",
                     $realtime, out_byte, out_header_flag, out_hop_address, out_packet_end);
          fail_count = fail_count + 1;
        end else begin
          w = frame_q.pop_front();
          if (out_byte !== w.octet || out_header_flag !== w.hdr ||
              out_hop_address !== w.hop || out_packet_end !== w.last) begin
            if (fail_count < 10)
              $display({"[%0t] mismatch: expected byte %02h hdr %0b hop %08h end %0b,",
                        " got byte %02h hdr %0b hop %08h end %0b"},
                       $realtime, w.octet, w.hdr, w.hop, w.last,
                       out_byte, out_header_flag, out_hop_address, out_packet_end);
            fail_count = fail_count + 1;
          end
        end
      end
    end
    pending <= frame_q.size();
  end

endmodule

>>> dv/ipv4_header_builder_tb.sv
// Testbench top for the IPv4 header builder: clock, reset, stimulus, receiver and verdict.
module ipv4_header_builder_tb;
  import ihb_pkg::*;

  localparam int LIMIT_CYCLES = 4_000_000;
  localparam int PHASE_WORDS  = 100;
  localparam int DRAIN_CYCLES = 10;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid          = 1'b0;
  logic        in_ready;
  logic        in_func           = FUNC_START;
  logic [31:0] in_dest_address   = 32'd0;
  logic [7:0]  in_proto_number   = 8'd0;
  logic [15:0] in_payload_length = 16'd0;
  logic [7:0]  in_data_byte      = 8'd0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_header_flag;
  logic [31:0] out_hop_address;
  logic        out_packet_end;

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = 3'd0;
  logic [31:0] pwdata  = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;

  // Stimulus bookkeeping
  int          send_idle = 0;      // percent of cycles the sender idles
  int          recv_idle = 0;      // percent of cycles the receiver stalls
  int          hold_off_cycles = 0; // long receiver stall requested by the stimulus
  int          word_count = 0;     // accepted words that are not strays
  int          owed = 0;           // payload words the block still expects
  logic [31:0] cur_local = 32'd0;
  int          cycle_count = 0;

  always #4 clk = ~clk;

  ipv4_header_builder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_dest_address  (in_dest_address),
    .in_proto_number  (in_proto_number),
    .in_payload_length(in_payload_length),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_header_flag  (out_header_flag),
    .out_hop_address  (out_hop_address),
    .out_packet_end   (out_packet_end),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  ipv4_header_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_dest_address  (in_dest_address),
    .in_proto_number  (in_proto_number),
    .in_payload_length(in_payload_length),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_header_flag  (out_header_flag),
    .out_hop_address  (out_hop_address),
    .out_packet_end   (out_packet_end),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: stall at random, or hold off for a long stretch on request so the
  // descriptor queue fills and the block backs up into its input.
  initial begin : receiver
    int stall;
    forever begin
      @(posedge clk);
      if (hold_off_cycles != 0) begin
        stall = hold_off_cycles;
        hold_off_cycles = 0;
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Write one register: setup cycle, access cycle, then release the bus.
  task automatic cfg_write(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_LOCAL) cur_local = value;
    @(posedge clk);
  endtask

  // Offer one word, idling first at the current rate, and hold it until accepted.
  task automatic send_word(input logic func, input logic [31:0] dest, input logic [7:0] proto,
                           input logic [15:0] len, input logic [7:0] data);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_func           <= func;
    in_dest_address   <= dest;
    in_proto_number   <= proto;
    in_payload_length <= len;
    in_data_byte      <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Start a packet; the data byte rides along as noise.
  task automatic send_start(input logic [31:0] dest, input logic [7:0] proto,
                            input logic [15:0] len);
    send_word(FUNC_START, dest, proto, len, 8'($urandom));
    word_count  = word_count + 1;
    owed = (len > MAX_PAYLOAD) ? int'(MAX_PAYLOAD) : int'(len);
  endtask

  // One payload byte; header fields carry noise. Strays are not counted.
  task automatic send_data(input logic [7:0] data);
    send_word(FUNC_PAYLOAD, $urandom, 8'($urandom), 16'($urandom), data);
    if (owed != 0) begin
      word_count = word_count + 1;
      owed = owed - 1;
    end
  endtask

  // Mostly well-formed packets with random content; some get abandoned early,
  // some are followed by stray bytes.
  task automatic random_packet();
    int          pick;
    int          nbytes;
    logic [15:0] len;
    logic [31:0] dest;
    pick = $urandom_range(99);
    if (pick < 50) len = 16'($urandom_range(6));
    else if (pick < 85) len = 16'($urandom_range(30, 7));
    else len = 16'($urandom);
    case ($urandom_range(9))
      0:          dest = cur_local;
      1, 2, 3, 4: dest = {cur_local[31:8], 8'($urandom)};
      default:    dest = $urandom;
    endcase
    send_start(dest, 8'($urandom), len);
    nbytes = owed;
    // abandon long packets after a few bytes to keep the run short
    if (nbytes > 40) nbytes = $urandom_range(5);
    else if ($urandom_range(9) == 0) nbytes = $urandom_range(nbytes);
    repeat (nbytes) send_data(8'($urandom));
    if ($urandom_range(9) == 0) repeat ($urandom_range(3, 1)) send_data(8'($urandom));
  endtask

  // Drop valid and wait until every expected word has come out, plus a margin
  // for strays still in flight.
  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int  phase_start;
    logic held;
    send_idle = 14;
    recv_idle = 53;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: subnet boundaries, empty and clamped lengths, strays,
    // a start that abandons a packet in progress.
    cfg_write(REG_LOCAL,   32'h0A00_0105);
    cfg_write(REG_GATEWAY, 32'h0A00_01FE);
    send_start(32'h0A00_0133, 8'd6, 16'd3);
    send_data(8'h00);
    send_data(8'hFF);
    send_data(8'hA5);
    send_data(8'h3C);                              // stray
    send_start(32'hFFFF_FFFF, 8'hFF, 16'd0);      // empty payload, off-subnet
    send_data(8'h81);                              // stray
    send_start(32'h0000_0000, 8'h00, 16'hFFFF);   // clamped length
    send_data(8'h5A);
    send_start(32'h0A00_0105, 8'd17, 16'd65516);  // abandons previous, clamped
    send_data(8'h01);
    send_start(32'h0A00_01FF, 8'd1, MAX_PAYLOAD);
    send_data(8'hC3);
    send_start(32'h0A00_0200, 8'h80, 16'd1);      // just above the local /24
    send_data(8'h7E);
    send_data(8'h18);                              // stray
    send_start(32'h0A00_00FF, 8'h7F, 16'd2);      // just below the local /24
    send_data(8'hAA);
    send_data(8'h55);
    wait_for_quiet();

    // Random phases: each with its own idle mix and address setting.
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle = 14;
          recv_idle = 53;
          cfg_write(REG_LOCAL, $urandom);
          cfg_write(REG_GATEWAY, $urandom);
        end
        1: begin
          send_idle = 53;
          recv_idle = 14;
          cfg_write(REG_LOCAL, 32'hFFFF_FFFF);
          cfg_write(REG_GATEWAY, 32'h0000_0000);
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
          cfg_write(REG_LOCAL, 32'h0000_0000);
          cfg_write(REG_GATEWAY, 32'hFFFF_FFFF);
        end
      endcase
      phase_start = word_count;
      held = 1'b0;
      while (word_count - phase_start < PHASE_WORDS) begin
        random_packet();
        if (p == 0 && !held && word_count - phase_start >= 40) begin
          hold_off_cycles = 300;
          held = 1'b1;
        end
      end
      if (p < 2) wait_for_quiet();
    end

    repeat (4) random_packet();
    wait_for_quiet();

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
